// ----- rtl/pls_pkg.sv -----
// ----------------------------------------------------------------------------
// pls_pkg: shared types and constants of the positional list store
// Widths, request and status codes, and the per-cell command used by the
// register row that holds the list entries.
// ----------------------------------------------------------------------------
package pls_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;

    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int POS_W   = 5;
    localparam int CAP_W   = 5;
    localparam int ENTRY_W = 5;
    localparam int REQ_W   = 2;
    localparam int ST_W    = 2;
    localparam int CMP_W   = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_READ   = 2'd2
    } req_t;

    typedef enum logic [ST_W-1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD       = 2'd0,
        CELL_LOAD       = 2'd1,
        CELL_FROM_LEFT  = 2'd2,
        CELL_FROM_RIGHT = 2'd3
    } cell_cmd_t;

endpackage

// ----- rtl/pls_cell.sv -----
// ----------------------------------------------------------------------------
// pls_cell: one slot of the list register row
// Holds one entry and each cycle keeps it, loads the new word, or takes the
// entry of its lower or upper neighbor.
// ----------------------------------------------------------------------------
module pls_cell
(
    input  logic                             clk,
    input  pls_pkg::cell_cmd_t               cmd,
    input  logic [pls_pkg::DATA_WIDTH-1:0]   load_data,
    input  logic [pls_pkg::DATA_WIDTH-1:0]   left_data,
    input  logic [pls_pkg::DATA_WIDTH-1:0]   right_data,
    output logic [pls_pkg::DATA_WIDTH-1:0]   q
);

    logic [pls_pkg::DATA_WIDTH-1:0] q_reg;
    logic [pls_pkg::DATA_WIDTH-1:0] q_next;

    always_comb
    begin
        case (cmd)
            pls_pkg::CELL_LOAD:       q_next = load_data;
            pls_pkg::CELL_FROM_LEFT:  q_next = left_data;
            pls_pkg::CELL_FROM_RIGHT: q_next = right_data;
            default:                  q_next = q_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

// ----- rtl/positional_list_store.sv -----
// ----------------------------------------------------------------------------
// positional_list_store: ordered list with insert, remove and read by position
// Each request word inserts a word at a position, removes the entry at a
// position, or reads it, and returns one result word.
//
// The request channel (in_valid, in_ready) carries req_type, position and
// write_value. The result channel (out_valid, out_ready) carries status,
// read_value, entry_count and is_full. The user must see that the capacity
// register is written through cfg_we and cfg_data only while no request is
// in flight; the block does not enforce it. Entries sit in a row of cells;
// on an insert or remove the cells from the position to the end load the
// new word or take a neighbor's entry in the same cycle. One request is
// accepted per cycle while results are taken. When the receiver stalls, the
// result holds and in_ready drops until it is taken; a new request is
// accepted in the cycle the pending result leaves. Reset empties the list,
// sets the capacity to 16 and clears out_valid; no clearing pass is needed.
// ----------------------------------------------------------------------------
module positional_list_store
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [pls_pkg::CAP_W-1:0]             cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [pls_pkg::REQ_W-1:0]             req_type,
    input  logic [pls_pkg::POS_W-1:0]             position,
    input  logic signed [pls_pkg::DATA_WIDTH-1:0] write_value,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [pls_pkg::ST_W-1:0]              status,
    output logic signed [pls_pkg::DATA_WIDTH-1:0] read_value,
    output logic [pls_pkg::ENTRY_W-1:0]           entry_count,
    output logic                                  is_full
);

    localparam int CW = pls_pkg::CMP_W;

    logic [pls_pkg::CAP_W-1:0]       capacity_reg;
    logic [pls_pkg::CNT_W-1:0]       count_reg;
    logic [pls_pkg::CNT_W-1:0]       count_next;
    logic                            out_valid_reg;
    logic [pls_pkg::ST_W-1:0]        status_reg;
    logic [pls_pkg::ST_W-1:0]        status_next;
    logic [pls_pkg::DATA_WIDTH-1:0]  read_value_reg;
    logic [pls_pkg::DATA_WIDTH-1:0]  read_value_next;
    logic [pls_pkg::ENTRY_W-1:0]     entry_count_reg;
    logic                            is_full_reg;
    logic                            is_full_next;

    logic [pls_pkg::DATA_WIDTH-1:0]  cell_q [pls_pkg::DEPTH];
    pls_pkg::cell_cmd_t              cell_cmd [pls_pkg::DEPTH];

    logic            accept;
    logic [CW-1:0]   cap_eff;
    logic [CW-1:0]   pos_w;
    logic [CW-1:0]   cnt_w;
    logic            insert_ok;
    logic            remove_ok;
    logic            read_ok;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        if (capacity_reg == '0)
        begin
            cap_eff = CW'(1);
        end
        else if (CW'(capacity_reg) > CW'(pls_pkg::DEPTH))
        begin
            cap_eff = CW'(pls_pkg::DEPTH);
        end
        else
        begin
            cap_eff = CW'(capacity_reg);
        end
    end

    assign pos_w = CW'(position);
    assign cnt_w = CW'(count_reg);

    assign insert_ok = (req_type == pls_pkg::REQ_INSERT) && (cnt_w < cap_eff)
                       && (pos_w <= cnt_w) && (pos_w < CW'(pls_pkg::DEPTH));
    assign remove_ok = (req_type == pls_pkg::REQ_REMOVE) && (pos_w < cnt_w);
    assign read_ok   = (req_type == pls_pkg::REQ_READ) && (pos_w < cnt_w);

    always_comb
    begin
        count_next      = count_reg;
        status_next     = pls_pkg::ST_RANGE;
        read_value_next = '0;
        case (req_type)
            pls_pkg::REQ_INSERT:
            begin
                if (cnt_w >= cap_eff)
                begin
                    status_next = pls_pkg::ST_FULL;
                end
                else if (insert_ok)
                begin
                    status_next = pls_pkg::ST_DONE;
                    count_next  = count_reg + pls_pkg::CNT_W'(1);
                end
            end
            pls_pkg::REQ_REMOVE:
            begin
                if (remove_ok)
                begin
                    status_next = pls_pkg::ST_DONE;
                    count_next  = count_reg - pls_pkg::CNT_W'(1);
                end
            end
            pls_pkg::REQ_READ:
            begin
                if (read_ok)
                begin
                    status_next     = pls_pkg::ST_DONE;
                    read_value_next = cell_q[position[pls_pkg::IDX_W-1:0]];
                end
            end
            default:
            begin
                status_next = pls_pkg::ST_RANGE;
            end
        endcase
        is_full_next = (CW'(count_next) >= cap_eff);
    end

    genvar gi;
    generate
        for (gi = 0; gi < pls_pkg::DEPTH; gi++)
        begin : g_cell
            localparam int LEFT  = (gi == 0) ? 0 : gi - 1;
            localparam int RIGHT = (gi == pls_pkg::DEPTH - 1) ? gi : gi + 1;

            always_comb
            begin
                cell_cmd[gi] = pls_pkg::CELL_HOLD;
                if (accept && insert_ok)
                begin
                    if (CW'(gi) == pos_w)
                    begin
                        cell_cmd[gi] = pls_pkg::CELL_LOAD;
                    end
                    else if ((CW'(gi) > pos_w) && (CW'(gi) <= cnt_w))
                    begin
                        cell_cmd[gi] = pls_pkg::CELL_FROM_LEFT;
                    end
                end
                else if (accept && remove_ok)
                begin
                    if ((CW'(gi) >= pos_w) && (CW'(gi + 1) < cnt_w))
                    begin
                        cell_cmd[gi] = pls_pkg::CELL_FROM_RIGHT;
                    end
                end
            end

            pls_cell u_cell
            (
                .clk        (clk),
                .cmd        (cell_cmd[gi]),
                .load_data  (write_value),
                .left_data  (cell_q[LEFT]),
                .right_data (cell_q[RIGHT]),
                .q          (cell_q[gi])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg  <= pls_pkg::CAP_RESET;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                capacity_reg <= cfg_data;
            end
            if (accept)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg      <= status_next;
            read_value_reg  <= read_value_next;
            entry_count_reg <= pls_pkg::ENTRY_W'(count_next);
            is_full_reg     <= is_full_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign read_value  = read_value_reg;
    assign entry_count = entry_count_reg;
    assign is_full     = is_full_reg;

    // The list never holds more entries than the row has cells.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CW'(count_reg) <= CW'(pls_pkg::DEPTH))
        else $error("entry count exceeds the row depth");

    // An accepted request always leaves a result in the output register.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("accepted request produced no result");

    // A successful insert grows the list by exactly one entry.
    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && insert_ok) |=> (count_reg == $past(count_reg) + pls_pkg::CNT_W'(1)))
        else $error("insert did not grow the list by one");

    // A pending result that is not taken keeps the request channel closed.
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !in_ready)
        else $error("request accepted while a result is stalled");

endmodule

// ----- verif/tb_positional_list_store.sv -----
// ----------------------------------------------------------------------------
// tb_positional_list_store: self-checking testbench of the positional list
// A mirror of the list predicts every result word from the accepted request
// words and the capacity register. Directed requests hit the empty, full and
// range cases first, then random phases at several capacities run, most with
// random idle bursts on both channels, and two long output stalls.
// ----------------------------------------------------------------------------
localparam logic [pls_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;

typedef struct packed {
    pls_pkg::status_t                status;
    logic [31:0]                     data;
    logic [pls_pkg::ENTRY_W-1:0]     count;
    logic                            full;
} list_result_t;

class list_mirror;
    logic [pls_pkg::DATA_WIDTH-1:0] slots [pls_pkg::DEPTH];
    int unsigned                    fill;
    logic [pls_pkg::CAP_W-1:0]      capacity;
    list_result_t                   awaited_results [$];
    int unsigned                    mismatches;
    int unsigned                    inserts_done;
    int unsigned                    removes_done;
    int unsigned                    reads_done;
    int unsigned                    full_rejects;
    int unsigned                    range_rejects;

    function new();
        foreach (slots[i]) slots[i] = '0;
        fill          = 0;
        capacity      = pls_pkg::CAP_RESET;
        mismatches    = 0;
        inserts_done  = 0;
        removes_done  = 0;
        reads_done    = 0;
        full_rejects  = 0;
        range_rejects = 0;
    endfunction

    function void set_capacity(input logic [pls_pkg::CAP_W-1:0] value);
        capacity = value;
    endfunction

    function int unsigned usable_capacity();
        if (capacity == 0)
            return 1;
        if (capacity > pls_pkg::DEPTH)
            return pls_pkg::DEPTH;
        return capacity;
    endfunction

    function void apply_request(input logic [pls_pkg::REQ_W-1:0] kind,
                                input logic [pls_pkg::POS_W-1:0] pos,
                                input logic [pls_pkg::DATA_WIDTH-1:0] value);
        int unsigned  cap;
        int           i;
        list_result_t r;
        cap      = usable_capacity();
        r.status = pls_pkg::ST_RANGE;
        r.data   = '0;
        case (kind)
            pls_pkg::REQ_INSERT:
            begin
                if (fill >= cap)
                    r.status = pls_pkg::ST_FULL;
                else if (pos <= fill && pos < pls_pkg::DEPTH)
                begin
                    for (i = fill; i > pos; i--)
                        slots[i] = slots[i-1];
                    slots[pos] = value;
                    fill++;
                    r.status = pls_pkg::ST_DONE;
                    inserts_done++;
                end
            end
            pls_pkg::REQ_REMOVE:
            begin
                if (pos < fill)
                begin
                    for (i = pos; i + 1 < fill; i++)
                        slots[i] = slots[i+1];
                    fill--;
                    r.status = pls_pkg::ST_DONE;
                    removes_done++;
                end
            end
            pls_pkg::REQ_READ:
            begin
                if (pos < fill)
                begin
                    r.data   = slots[pos];
                    r.status = pls_pkg::ST_DONE;
                    reads_done++;
                end
            end
            default:
            begin
            end
        endcase
        if (r.status == pls_pkg::ST_FULL)
            full_rejects++;
        else if (r.status == pls_pkg::ST_RANGE)
            range_rejects++;
        r.count = fill[pls_pkg::ENTRY_W-1:0];
        r.full  = (fill >= cap);
        awaited_results.push_back(r);
    endfunction

    function void compare_result(input logic [pls_pkg::ST_W-1:0] st, input logic [31:0] data,
                                 input logic [pls_pkg::ENTRY_W-1:0] count, input logic full);
        list_result_t want;
        if (awaited_results.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("Unexpected result word: status %0d data %h count %0d full %0d",
                         st, data, count, full);
            return;
        end
        want = awaited_results.pop_front();
        if (want.status !== st || want.data !== data || want.count !== count
            || want.full !== full)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display({"Mismatch: expected status %0d data %h count %0d full %0d, ",
                          "got status %0d data %h count %0d full %0d"},
                         want.status, want.data, want.count, want.full,
                         st, data, count, full);
        end
    endfunction
endclass

module tb_positional_list_store;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int STALL_CYCLES = 60;

    logic                                  clk;
    logic                                  rst_n;
    logic                                  cfg_we;
    logic [pls_pkg::CAP_W-1:0]             cfg_data;
    logic                                  in_valid;
    logic                                  in_ready;
    logic [pls_pkg::REQ_W-1:0]             req_type;
    logic [pls_pkg::POS_W-1:0]             position;
    logic signed [pls_pkg::DATA_WIDTH-1:0] write_value;
    logic                                  out_valid;
    logic                                  out_ready;
    logic [pls_pkg::ST_W-1:0]              status;
    logic signed [pls_pkg::DATA_WIDTH-1:0] read_value;
    logic [pls_pkg::ENTRY_W-1:0]           entry_count;
    logic                                  is_full;

    list_mirror  mirror;
    bit          gaps_on;
    bit          stall_request;
    int unsigned cycle_count;
    int unsigned requests_sent;
    int unsigned settings_used;

    positional_list_store dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .position    (position),
        .write_value (write_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .read_value  (read_value),
        .entry_count (entry_count),
        .is_full     (is_full)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (stall_request)
            begin
                stall_request = 1'b0;
                out_ready <= 1'b0;
                repeat (STALL_CYCLES) @(posedge clk);
            end
            else if (gaps_on && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            mirror.compare_result(status, read_value, entry_count, is_full);
    end

    task automatic send_request(input logic [pls_pkg::REQ_W-1:0] kind,
                                input logic [pls_pkg::POS_W-1:0] pos,
                                input logic [pls_pkg::DATA_WIDTH-1:0] value);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        req_type    <= kind;
        position    <= pos;
        write_value <= value;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        mirror.apply_request(kind, pos, value);
        requests_sent++;
    endtask

    task automatic write_capacity(input logic [pls_pkg::CAP_W-1:0] value);
        in_valid <= 1'b0;
        while (mirror.awaited_results.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        mirror.set_capacity(value);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic run_phase(input logic [pls_pkg::CAP_W-1:0] cap, input int items,
                             input int ins_pct, input bit hold_output);
        int                             n;
        int unsigned                    roll;
        logic [pls_pkg::REQ_W-1:0]      kind;
        logic [pls_pkg::POS_W-1:0]      pos;
        logic [pls_pkg::DATA_WIDTH-1:0] value;
        write_capacity(cap);
        if (hold_output)
            stall_request = 1'b1;
        for (n = 0; n < items; n++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < ins_pct)
                kind = pls_pkg::REQ_INSERT;
            else if (roll < ins_pct + 30)
                kind = pls_pkg::REQ_REMOVE;
            else if (roll < 97)
                kind = pls_pkg::REQ_READ;
            else
                kind = REQ_UNUSED;
            if ($urandom_range(0, 6) == 0)
                pos = pls_pkg::POS_W'($urandom_range(0, 31));
            else if (kind == pls_pkg::REQ_INSERT)
                pos = pls_pkg::POS_W'($urandom_range(0, mirror.fill));
            else if (mirror.fill == 0)
                pos = '0;
            else
                pos = pls_pkg::POS_W'($urandom_range(0, mirror.fill - 1));
            case ($urandom_range(0, 9))
                0:       value = 32'h7FFF_FFFF;
                1:       value = 32'h8000_0000;
                2:       value = 32'h0000_0000;
                3:       value = 32'hFFFF_FFFF;
                default: value = $urandom;
            endcase
            send_request(kind, pos, value);
        end
    endtask

    initial
    begin
        mirror        = new();
        gaps_on       = 1'b1;
        stall_request = 1'b0;
        requests_sent = 0;
        settings_used = 0;
        rst_n       <= 1'b0;
        cfg_we      <= 1'b0;
        cfg_data    <= '0;
        in_valid    <= 1'b0;
        req_type    <= pls_pkg::REQ_INSERT;
        position    <= '0;
        write_value <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(pls_pkg::REQ_READ,   5'd0,  32'h0);
        send_request(pls_pkg::REQ_REMOVE, 5'd0,  32'h0);
        send_request(pls_pkg::REQ_INSERT, 5'd1,  32'h1234_5678);
        send_request(pls_pkg::REQ_INSERT, 5'd0,  32'h7FFF_FFFF);
        send_request(pls_pkg::REQ_INSERT, 5'd0,  32'h8000_0000);
        send_request(pls_pkg::REQ_INSERT, 5'd2,  32'hFFFF_FFFF);
        send_request(pls_pkg::REQ_INSERT, 5'd1,  32'h0000_0000);
        send_request(pls_pkg::REQ_INSERT, 5'd31, 32'h5555_5555);
        send_request(pls_pkg::REQ_INSERT, 5'd16, 32'hAAAA_AAAA);
        send_request(pls_pkg::REQ_READ,   5'd0,  32'h0);
        send_request(pls_pkg::REQ_READ,   5'd1,  32'h0);
        send_request(pls_pkg::REQ_READ,   5'd2,  32'h0);
        send_request(pls_pkg::REQ_READ,   5'd3,  32'h0);
        send_request(pls_pkg::REQ_READ,   5'd4,  32'h0);
        send_request(pls_pkg::REQ_READ,   5'd31, 32'h0);
        send_request(REQ_UNUSED,          5'd0,  32'hDEAD_BEEF);
        send_request(pls_pkg::REQ_REMOVE, 5'd1,  32'h0);
        send_request(pls_pkg::REQ_REMOVE, 5'd3,  32'h0);
        send_request(pls_pkg::REQ_REMOVE, 5'd2,  32'h0);
        send_request(pls_pkg::REQ_READ,   5'd0,  32'h0);
        send_request(pls_pkg::REQ_READ,   5'd1,  32'h0);

        // Lower the capacity below the current count; the list reports full.
        write_capacity(5'd1);
        send_request(pls_pkg::REQ_INSERT, 5'd0,  32'h0BAD_F00D);
        send_request(pls_pkg::REQ_REMOVE, 5'd0,  32'h0);
        send_request(pls_pkg::REQ_INSERT, 5'd0,  32'h0BAD_F00D);
        send_request(pls_pkg::REQ_REMOVE, 5'd0,  32'h0);
        send_request(pls_pkg::REQ_INSERT, 5'd0,  32'h2AAA_AAAA);
        write_capacity(5'd0);
        send_request(pls_pkg::REQ_INSERT, 5'd0,  32'h1111_1111);
        send_request(pls_pkg::REQ_REMOVE, 5'd0,  32'h0);
        send_request(pls_pkg::REQ_INSERT, 5'd0,  32'h2222_2222);

        run_phase(5'd16, 100, 60, 1'b0);
        run_phase(5'd4,  100, 25, 1'b1);
        run_phase(5'd31, 100, 60, 1'b0);
        run_phase(5'd1,  100, 25, 1'b0);
        run_phase(5'd8,  100, 60, 1'b1);
        run_phase(5'd0,  100, 25, 1'b0);
        run_phase(5'd2,  100, 60, 1'b0);
        run_phase(5'd16, 100, 60, 1'b0);
        run_phase(5'd12, 50,  25, 1'b0);
        gaps_on = 1'b0;
        run_phase(5'd16, 150, 60, 1'b0);

        in_valid <= 1'b0;
        while (mirror.awaited_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (mirror.awaited_results.size() != 0)
        begin
            $display("%0d result words never arrived", mirror.awaited_results.size());
            mirror.mismatches += mirror.awaited_results.size();
        end

        $display("Sent %0d request words under %0d capacity settings, with output stalls.",
                 requests_sent, settings_used);
        $display("%0d inserts, %0d removes, %0d reads done; %0d full and %0d range rejections.",
                 mirror.inserts_done, mirror.removes_done, mirror.reads_done,
                 mirror.full_rejects, mirror.range_rejects);
        if (mirror.mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/pls_pkg.sv
rtl/pls_cell.sv
rtl/positional_list_store.sv
verif/tb_positional_list_store.sv
